// ----- hw/rtl/cla_pkg.sv -----
// Shared types, codes and helpers for the control lease arbiter.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package cla_pkg;

   localparam int unsigned TIMEOUT_W = 20;
   localparam int unsigned CONN_W    = 64;
   localparam int unsigned TAG_W     = 32;
   localparam int unsigned CTR_W     = 32;
   localparam int unsigned EPOCH_W   = 32;
   localparam int unsigned TIME_W    = 64;
   localparam int unsigned SESS_W    = 64;

   localparam logic [CTR_W-1:0] SERIAL_HALF = 32'h8000_0000;

   typedef enum logic [2:0] {
      CMD_REQUEST    = 3'd0,
      CMD_RELEASE    = 3'd1,
      CMD_HEARTBEAT  = 3'd2,
      CMD_TICK       = 3'd3,
      CMD_DISCONNECT = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED       = 3'd0,
      ST_ALREADY        = 3'd1,
      ST_DENIED_HELD    = 3'd2,
      ST_DENIED_PROFILE = 3'd3,
      ST_INVALID        = 3'd4,
      ST_REFUSED        = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      LINK_OFFLINE = 2'd0,
      LINK_ONLINE  = 2'd1,
      LINK_STALE   = 2'd2
   } link_type;

   typedef enum logic [1:0] {
      KIND_OTHER   = 2'd0,
      KIND_CORE    = 2'd1,
      KIND_PANEL   = 2'd2,
      KIND_SERVICE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_TIMEOUT = 2'd0,
      REG_PROFILE = 2'd1,
      REG_SESSION = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_ms;
      logic                 profile;
      logic [SESS_W-1:0]    session;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        command;
      logic [CONN_W-1:0] conn_id;
      logic [TAG_W-1:0]  machine_tag;
      logic [1:0]        client_kind;
      logic              prio_window;
      logic [SESS_W-1:0] beat_session;
      logic [CTR_W-1:0]  beat_counter;
      logic [TIME_W-1:0] now_ms;
   } item_type;

   typedef struct packed {
      status_type         status;
      logic [EPOCH_W-1:0] epoch;
      link_type           link;
      logic [TAG_W-1:0]   owner_tag;
      logic [CONN_W-1:0]  bound_connection;
   } result_type;

   // Standalone panel admits only local clients; core preferred admits core
   // always and local clients only after the core window closes.
   function automatic logic profile_allows(logic profile, logic [1:0] kind,
                                           logic window);
      logic is_local;
      is_local = (kind == KIND_PANEL) || (kind == KIND_SERVICE);
      if (profile) begin
         return is_local;
      end
      if (kind == KIND_CORE) begin
         return 1'b1;
      end
      return is_local && !window;
   endfunction

   // Skip zero on wrap: zero means never owned.
   function automatic logic [EPOCH_W-1:0] next_epoch(logic [EPOCH_W-1:0] cur);
      logic [EPOCH_W-1:0] sum;
      sum = cur + EPOCH_W'(1);
      return (sum == '0) ? EPOCH_W'(1) : sum;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cla_csr.sv -----
// Configuration registers of the control lease arbiter.
// Depends on cla_pkg for the register index codes and the config bundle.
`default_nettype none

module cla_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [63:0]             csr_wdata,
   output cla_pkg::cfg_type             cfg
);
   import cla_pkg::*;

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 profile_ff;
   logic [SESS_W-1:0]    session_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_W'(6000);
         profile_ff <= 1'b0;
         session_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_TIMEOUT: timeout_ff <= csr_wdata[TIMEOUT_W-1:0];
            REG_PROFILE: profile_ff <= csr_wdata[0];
            REG_SESSION: session_ff <= csr_wdata[SESS_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.timeout_ms = timeout_ff;
   assign cfg.profile    = profile_ff;
   assign cfg.session    = session_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/cla_core.sv -----
// Lease state registers and the per-item decision logic.
// Depends on cla_pkg; result is combinational from the staged item and state.
`default_nettype none

module cla_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire cla_pkg::item_type   item,
   input  wire cla_pkg::cfg_type    cfg,
   output cla_pkg::result_type      result
);
   import cla_pkg::*;

   link_type           link_ff,    link_in;
   logic [TAG_W-1:0]   owner_ff,   owner_in;
   logic [1:0]         okind_ff,   okind_in;
   logic [CONN_W-1:0]  lease_ff,   lease_in;
   logic [CONN_W-1:0]  bconn_ff,   bconn_in;
   logic [CTR_W-1:0]   lctr_ff,    lctr_in;
   logic [TIME_W-1:0]  lbt_ff,     lbt_in;
   logic [EPOCH_W-1:0] epoch_ff,   epoch_in;
   status_type         status;

   logic               conn_zero;
   logic               tag_zero;
   logic               held;
   logic               held_by_tag;
   logic               takeover_ok;
   logic [CTR_W-1:0]   ctr_diff;
   logic               ctr_newer;
   logic [TIME_W-1:0]  age;
   logic               expired;

   always_comb begin
      conn_zero   = (item.conn_id == '0);
      tag_zero    = (item.machine_tag == '0);
      held        = (link_ff == LINK_ONLINE) && (owner_ff != '0);
      held_by_tag = !tag_zero && (owner_ff == item.machine_tag);
      takeover_ok = (item.client_kind == KIND_CORE) &&
                    ((okind_ff == KIND_PANEL) || (okind_ff == KIND_SERVICE));
      ctr_diff    = item.beat_counter - lctr_ff;
      ctr_newer   = (ctr_diff != '0) && (ctr_diff < SERIAL_HALF);
      age         = item.now_ms - lbt_ff;
      expired     = (owner_ff != '0) && (age >= TIME_W'(cfg.timeout_ms));

      link_in  = link_ff;
      owner_in = owner_ff;
      okind_in = okind_ff;
      lease_in = lease_ff;
      bconn_in = bconn_ff;
      lctr_in  = lctr_ff;
      lbt_in   = lbt_ff;
      epoch_in = epoch_ff;
      status   = ST_REFUSED;

      unique case (cmd_type'(item.command))
         CMD_REQUEST: begin
            if (conn_zero || tag_zero) begin
               status = ST_INVALID;
            end else if (!profile_allows(cfg.profile, item.client_kind,
                                         item.prio_window)) begin
               status = ST_DENIED_PROFILE;
            end else if (held && (owner_ff == item.machine_tag)) begin
               lease_in = item.conn_id;
               lbt_in   = item.now_ms;
               status   = ST_ALREADY;
            end else if (held && !takeover_ok) begin
               status = ST_DENIED_HELD;
            end else begin
               owner_in = item.machine_tag;
               okind_in = item.client_kind;
               lease_in = item.conn_id;
               bconn_in = item.conn_id;
               lctr_in  = '0;
               lbt_in   = item.now_ms;
               link_in  = LINK_ONLINE;
               epoch_in = next_epoch(epoch_ff);
               status   = ST_ACCEPTED;
            end
         end
         CMD_RELEASE: begin
            if (held_by_tag) begin
               owner_in = '0;
               okind_in = '0;
               lease_in = '0;
               bconn_in = '0;
               lctr_in  = '0;
               link_in  = LINK_OFFLINE;
               epoch_in = next_epoch(epoch_ff);
               status   = ST_ACCEPTED;
            end
         end
         CMD_HEARTBEAT: begin
            if (conn_zero || (item.beat_session != cfg.session)) begin
               status = ST_INVALID;
            end else if ((lease_ff != '0) && (lease_ff != item.conn_id) &&
                         (link_ff == LINK_ONLINE) && !held_by_tag) begin
               status = ST_REFUSED;
            end else if ((bconn_ff == item.conn_id) && (lctr_ff != '0) &&
                         !ctr_newer) begin
               // drop replayed counter
               status = ST_REFUSED;
            end else begin
               owner_in = item.machine_tag;
               okind_in = tag_zero ? 2'(KIND_OTHER) : item.client_kind;
               lease_in = item.conn_id;
               bconn_in = item.conn_id;
               lctr_in  = item.beat_counter;
               lbt_in   = item.now_ms;
               link_in  = LINK_ONLINE;
               status   = ST_ACCEPTED;
            end
         end
         CMD_TICK: begin
            if (expired) begin
               link_in  = LINK_STALE;
               lease_in = '0;
               owner_in = '0;
               okind_in = '0;
               epoch_in = next_epoch(epoch_ff);
               status   = ST_ACCEPTED;
            end
         end
         CMD_DISCONNECT: begin
            if (!conn_zero && ((lease_ff == item.conn_id) ||
                               (bconn_ff == item.conn_id))) begin
               lease_in = '0;
               bconn_in = '0;
               lctr_in  = '0;
               link_in  = LINK_OFFLINE;
               status   = ST_ACCEPTED;
            end
         end
         default: status = ST_REFUSED;
      endcase

      result.status           = status;
      result.epoch            = epoch_in;
      result.link             = link_in;
      result.owner_tag        = owner_in;
      result.bound_connection = lease_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff  <= LINK_OFFLINE;
         owner_ff <= '0;
         okind_ff <= '0;
         lease_ff <= '0;
         bconn_ff <= '0;
         lctr_ff  <= '0;
         lbt_ff   <= '0;
         epoch_ff <= '0;
      end else if (advance) begin
         link_ff  <= link_in;
         owner_ff <= owner_in;
         okind_ff <= okind_in;
         lease_ff <= lease_in;
         bconn_ff <= bconn_in;
         lctr_ff  <= lctr_in;
         lbt_ff   <= lbt_in;
         epoch_ff <= epoch_in;
      end
   end

   // State moves only when an item advances.
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(epoch_ff) && $stable(owner_ff) &&
                   $stable(lease_ff) && $stable(link_ff))
      else $error("lease state changed without an item");

   // Once owned, the epoch never returns to zero.
   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0 |=> epoch_ff != '0)
      else $error("epoch wrapped to zero");

   // A rejected item leaves the lease untouched.
   a_reject_no_change: assert property (@(posedge clock) disable iff (reset)
      advance && (status != ST_ACCEPTED) && (status != ST_ALREADY) |=>
         $stable(epoch_ff) && $stable(owner_ff) && $stable(lease_ff) &&
         $stable(link_ff) && $stable(lctr_ff))
      else $error("rejected item modified lease state");

   // Reclaim by the holder rebinds without a new epoch.
   a_already_keeps_epoch: assert property (@(posedge clock) disable iff (reset)
      advance && (status == ST_ALREADY) |=> $stable(epoch_ff) &&
                                           $stable(owner_ff))
      else $error("reclaim changed epoch or owner");

endmodule

`default_nettype wire

// ----- hw/rtl/control_lease_arbiter.sv -----
// Top level of the control lease arbiter: input stage, result register.
// Depends on cla_pkg, cla_csr and cla_core.
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         req_valid/req_stall  command, connection, tag, kind,
//                                             window, session, counter, time
//   rsp_*     out        rsp_valid/rsp_stall  status, epoch, link, owner, conn
//   csr_*     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low; an accepted item sits
// in the input stage, and its result is registered onto rsp_* as it leaves.
// Lease state updates as the item leaves the input stage, so the following
// item sees it at once. Reset clears lease state and loads register defaults.
// A stalled result holds; the input stage still takes an item behind it.
`default_nettype none

module control_lease_arbiter (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [63:0] req_conn_id,
   input  wire logic [31:0] req_machine_tag,
   input  wire logic [1:0]  req_client_kind,
   input  wire logic        req_prio_window,
   input  wire logic [63:0] req_beat_session,
   input  wire logic [31:0] req_beat_counter,
   input  wire logic [63:0] req_now_ms,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_epoch,
   output logic [1:0]       rsp_link_state,
   output logic [31:0]      rsp_owner_tag,
   output logic [63:0]      rsp_bound_connection,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import cla_pkg::*;

   cfg_type    cfg;
   item_type   item_ff,  item_in;
   logic       stage_valid_ff;
   result_type core_result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       out_ready;
   logic       advance;
   logic       req_take;

   cla_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cla_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = stage_valid_ff && out_ready;
   assign req_stall = stage_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in.command      = req_command;
      item_in.conn_id      = req_conn_id;
      item_in.machine_tag  = req_machine_tag;
      item_in.client_kind  = req_client_kind;
      item_in.prio_window  = req_prio_window;
      item_in.beat_session = req_beat_session;
      item_in.beat_counter = req_beat_counter;
      item_in.now_ms       = req_now_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_take) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_epoch            = rsp_ff.epoch;
   assign rsp_link_state       = rsp_ff.link;
   assign rsp_owner_tag        = rsp_ff.owner_tag;
   assign rsp_bound_connection = rsp_ff.bound_connection;

endmodule

`default_nettype wire
